@@ hdl/cpst_pkg.sv @@
package cpst_pkg;

   // Ring geometry and frame layout
   localparam int RING_FRAMES     = 32;
   localparam int RING_AW         = $clog2(RING_FRAMES);
   localparam int BYTES_PER_FRAME = 7;
   localparam int FRAME_BYTES     = 8;
   localparam int HDR_NIBBLE      = 4;
   localparam logic [3:0] HDR_COUNT_MASK = 4'h F;

   // Reciprocal of BYTES_PER_FRAME scaled by 2**RECIP_SHIFT, exact for 8-bit operands
   localparam int RECIP_MULT  = 293;
   localparam int RECIP_SHIFT = 11;

   localparam logic [7:0] DROP_LIMIT_RESET = 8'd255;

   typedef enum logic [1:0] {
      MODE_HEADER       = 2'd0,
      MODE_DATA         = 2'd1,
      MODE_MAILBOX_FREE = 2'd2,
      MODE_RESERVED     = 2'd3
   } mode_type;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_FETCH,
      ST_RESP
   } ctrl_state_type;

   // Controller to datapath
   typedef struct packed {
      logic accept;
      logic fetch;
   } dp_cmd_type;

   // Datapath to controller
   typedef struct packed {
      logic fetch_needed;
   } dp_status_type;

   // ceil(len / BYTES_PER_FRAME) by reciprocal multiply
   function automatic logic [4:0] frames_needed(input logic [6:0] len);
      logic [7:0]  sum;
      logic [16:0] prod;
      sum  = {1'b0, len} + 8'(BYTES_PER_FRAME - 1);
      prod = {9'd0, sum} * 17'(RECIP_MULT);
      return prod[RECIP_SHIFT +: 5];
   endfunction

endpackage

@@ hdl/cpst_if.sv @@
interface cpst_req_if;
   import cpst_pkg::*;

   logic        valid;
   logic        ready;
   logic [1:0]  mode;
   logic [10:0] can_id;
   logic [6:0]  packet_length;
   logic [7:0]  data_byte;

   modport source (output valid, mode, can_id, packet_length, data_byte, input ready);
   modport sink   (input valid, mode, can_id, packet_length, data_byte, output ready);
endinterface

interface cpst_rsp_if;
   import cpst_pkg::*;

   logic        valid;
   logic        ready;
   logic        frame_valid;
   logic [10:0] frame_id;
   logic [63:0] frame_bytes;
   logic        packet_dropped;
   logic [7:0]  drop_count;
   logic [4:0]  free_frame_count;

   modport source (output valid, frame_valid, frame_id, frame_bytes, packet_dropped,
                   drop_count, free_frame_count, input ready);
   modport sink   (input valid, frame_valid, frame_id, frame_bytes, packet_dropped,
                   drop_count, free_frame_count, output ready);
endinterface

@@ hdl/can_packet_segmenting_tx_ring_unit.sv @@
// CAN packet segmenter with a 32-frame transmit ring.
//
// req_bus carries one request per handshake: a packet header (identifier and
// length), one payload byte, or a mailbox-free event. Packets are cut into
// 8-byte frames (header byte with frame index and count, then 7 data bytes)
// and become visible to the sender only after their last byte. A header that
// does not fit in the free frames drops the whole packet and bumps a
// saturating drop counter whose limit is written through csr_write_*.
//
// rsp_bus returns exactly one response per request: the frame handed out on a
// mailbox-free event (if any), the drop flag, the drop counter and the free
// frame count. Requests are handled one at a time: the response is valid in the
// cycle after acceptance, or after the fetch state for a mailbox-free event that
// reads the frame store (its registered read port). A new request is taken
// only after the previous response has been accepted.
// While rsp_bus is stalled the response holds and req_ready stays low.
// Reset empties the ring, closes any open packet, clears the counter and sets
// the limit to 255. Frame store contents need no clearing.
module can_packet_segmenting_tx_ring_unit (
   input  logic       clock,
   input  logic       reset,
   cpst_req_if.sink   req_bus,
   cpst_rsp_if.source rsp_bus,
   input  logic       csr_write_enable,
   input  logic [7:0] csr_write_data
);
   import cpst_pkg::*;

   dp_cmd_type    cmd;
   dp_status_type status;

   // Sequencer
   cpst_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_bus.valid),
      .req_ready (req_bus.ready),
      .rsp_valid (rsp_bus.valid),
      .rsp_ready (rsp_bus.ready),
      .cmd       (cmd),
      .status    (status)
   );

   // Ring, assembly and counters
   cpst_dpath u_dpath (
      .clock                (clock),
      .reset                (reset),
      .cmd                  (cmd),
      .status               (status),
      .req_mode             (req_bus.mode),
      .req_can_id           (req_bus.can_id),
      .req_packet_length    (req_bus.packet_length),
      .req_data_byte        (req_bus.data_byte),
      .csr_write_enable     (csr_write_enable),
      .csr_write_data       (csr_write_data),
      .rsp_frame_valid      (rsp_bus.frame_valid),
      .rsp_frame_id         (rsp_bus.frame_id),
      .rsp_frame_bytes      (rsp_bus.frame_bytes),
      .rsp_packet_dropped   (rsp_bus.packet_dropped),
      .rsp_drop_count       (rsp_bus.drop_count),
      .rsp_free_frame_count (rsp_bus.free_frame_count)
   );

endmodule

@@ hdl/cpst_ctrl.sv @@
module cpst_ctrl (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_valid,
   output logic                   req_ready,
   output logic                   rsp_valid,
   input  logic                   rsp_ready,
   output cpst_pkg::dp_cmd_type   cmd,
   input  cpst_pkg::dp_status_type status
);
   import cpst_pkg::*;

   ctrl_state_type state_ff, state_in;

   // State register
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   // Next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               state_in = status.fetch_needed ? ST_FETCH : ST_RESP;
            end
         end
         ST_FETCH: begin
            state_in = ST_RESP;
         end
         ST_RESP: begin
            if (rsp_ready) begin
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // Outputs
   always_comb begin
      req_ready  = 1'b0;
      rsp_valid  = 1'b0;
      cmd.accept = 1'b0;
      cmd.fetch  = 1'b0;
      case (state_ff)
         ST_IDLE: begin
            req_ready  = 1'b1;
            cmd.accept = req_valid;
         end
         ST_FETCH: begin
            cmd.fetch = 1'b1;
         end
         ST_RESP: begin
            rsp_valid = 1'b1;
         end
         default: begin
            req_ready = 1'b0;
         end
      endcase
   end

endmodule

@@ hdl/cpst_dpath.sv @@
module cpst_dpath (
   input  logic                    clock,
   input  logic                    reset,
   input  cpst_pkg::dp_cmd_type    cmd,
   output cpst_pkg::dp_status_type status,
   input  logic [1:0]              req_mode,
   input  logic [10:0]             req_can_id,
   input  logic [6:0]              req_packet_length,
   input  logic [7:0]              req_data_byte,
   input  logic                    csr_write_enable,
   input  logic [7:0]              csr_write_data,
   output logic                    rsp_frame_valid,
   output logic [10:0]             rsp_frame_id,
   output logic [63:0]             rsp_frame_bytes,
   output logic                    rsp_packet_dropped,
   output logic [7:0]              rsp_drop_count,
   output logic [4:0]              rsp_free_frame_count
);
   import cpst_pkg::*;

   localparam int ENTRY_W = 11 + 8 * FRAME_BYTES;

   // Ring pointers and packet assembly state
   logic [RING_AW-1:0] pub_head_ff, tail_ff, rd_addr_ff;
   logic [6:0]         bytes_ff, plen_ff;
   logic [10:0]        pid_ff;
   logic [4:0]         pcount_ff, fidx_ff;
   logic [2:0]         off_ff;
   logic               asm_ff;
   logic [7:0]         drops_ff, limit_ff;
   logic [63:0]        buf_ff, buf_in;
   logic               fvalid_ff, dropped_ff;
   logic [ENTRY_W-1:0] rd_data_ff;
   logic [ENTRY_W-1:0] ring_mem_ff [RING_FRAMES];

   logic               is_header, is_data, is_send;
   logic [RING_AW-1:0] used, free_cnt, wr_addr;
   logic [4:0]         need;
   logic               lack;
   logic [6:0]         bytes_inc;
   logic               last_byte, frame_full, wr_en;
   logic [7:0]         hdr;

   assign is_header = cmd.accept && (req_mode == MODE_HEADER);
   assign is_data   = cmd.accept && (req_mode == MODE_DATA) && asm_ff;
   assign is_send   = req_mode == MODE_MAILBOX_FREE;

   // Ring occupancy
   assign used     = pub_head_ff - tail_ff;
   assign free_cnt = RING_AW'(RING_FRAMES - 1) - used;
   assign need     = frames_needed(req_packet_length);
   assign lack     = {1'b0, free_cnt} < {1'b0, need};

   assign status.fetch_needed = is_send && (tail_ff != pub_head_ff);

   // Byte placement into the frame being staged
   assign bytes_inc  = bytes_ff + 7'd1;
   assign last_byte  = bytes_inc >= plen_ff;
   assign frame_full = off_ff == 3'(BYTES_PER_FRAME - 1);
   assign hdr        = {fidx_ff[HDR_NIBBLE-1:0], pcount_ff[3:0] & HDR_COUNT_MASK};
   assign wr_addr    = pub_head_ff + RING_AW'(fidx_ff);
   assign wr_en      = is_data && (frame_full || last_byte);

   always_comb begin
      buf_in = (off_ff == 3'd0) ? {56'd0, hdr} : buf_ff;
      for (int k = 1; k < FRAME_BYTES; k++) begin
         if (off_ff == 3'(k - 1)) begin
            buf_in[8*k +: 8] = req_data_byte;
         end
      end
   end

   // Frame store: one full frame written per completed frame
   always_ff @(posedge clock) begin
      if (wr_en) begin
         ring_mem_ff[wr_addr] <= {pid_ff, buf_in};
      end
      if (cmd.fetch) begin
         rd_data_ff <= ring_mem_ff[rd_addr_ff];
      end
   end

   // Staging buffer and read address
   always_ff @(posedge clock) begin
      if (is_data) begin
         buf_ff <= buf_in;
      end
      if (cmd.accept) begin
         rd_addr_ff <= tail_ff;
      end
   end

   // Limit register
   always_ff @(posedge clock) begin
      if (reset) begin
         limit_ff <= DROP_LIMIT_RESET;
      end else if (csr_write_enable) begin
         limit_ff <= csr_write_data;
      end
   end

   // Control state update per accepted request
   always_ff @(posedge clock) begin
      if (reset) begin
         pub_head_ff <= '0;
         tail_ff     <= '0;
         bytes_ff    <= '0;
         plen_ff     <= '0;
         pid_ff      <= '0;
         pcount_ff   <= '0;
         fidx_ff     <= '0;
         off_ff      <= '0;
         asm_ff      <= 1'b0;
         drops_ff    <= '0;
         fvalid_ff   <= 1'b0;
         dropped_ff  <= 1'b0;
      end else if (cmd.accept) begin
         fvalid_ff  <= status.fetch_needed;
         dropped_ff <= is_header && lack;
         if (status.fetch_needed) begin
            tail_ff <= tail_ff + RING_AW'(1);
         end
         if (is_header) begin
            bytes_ff <= '0;
            fidx_ff  <= '0;
            off_ff   <= '0;
            if (lack) begin
               asm_ff <= 1'b0;
               if (drops_ff < limit_ff) begin
                  drops_ff <= drops_ff + 8'd1;
               end
            end else begin
               drops_ff  <= '0;
               pid_ff    <= req_can_id;
               plen_ff   <= req_packet_length;
               pcount_ff <= need;
               asm_ff    <= req_packet_length != 7'd0;
            end
         end else if (is_data) begin
            bytes_ff <= bytes_inc;
            if (frame_full) begin
               off_ff  <= '0;
               fidx_ff <= fidx_ff + 5'd1;
            end else begin
               off_ff <= off_ff + 3'd1;
            end
            if (last_byte) begin
               pub_head_ff <= pub_head_ff + RING_AW'(pcount_ff);
               asm_ff      <= 1'b0;
            end
         end
      end
   end

   // Response fields
   assign rsp_frame_valid      = fvalid_ff;
   assign rsp_frame_id         = fvalid_ff ? rd_data_ff[ENTRY_W-1 -: 11] : 11'd0;
   assign rsp_frame_bytes      = fvalid_ff ? rd_data_ff[63:0] : 64'd0;
   assign rsp_packet_dropped   = dropped_ff;
   assign rsp_drop_count       = drops_ff;
   assign rsp_free_frame_count = 5'(free_cnt);

endmodule

@@ hdl/cpst_checker.sv @@
module cpst_checker (
   input logic        clock,
   input logic        reset,
   input logic        req_valid,
   input logic        req_ready,
   input logic        rsp_valid,
   input logic        rsp_ready,
   input logic        frame_valid,
   input logic [10:0] frame_id,
   input logic [63:0] frame_bytes,
   input logic        packet_dropped,
   input logic [7:0]  drop_count,
   input logic [4:0]  free_frame_count
);

   // Stalled response holds its payload
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(frame_valid) && $stable(frame_id)
         && $stable(frame_bytes) && $stable(packet_dropped) && $stable(drop_count)
         && $stable(free_frame_count))
      else $error("response changed while stalled");

   // One request in flight: no new request until the response is gone
   a_one_inflight: assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready |=> !req_ready)
      else $error("request accepted while previous one in flight");

   a_no_overlap: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> !req_ready)
      else $error("request ready while response pending");

   // Without a frame the frame fields read zero
   a_empty_frame: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !frame_valid |-> frame_id == 11'd0 && frame_bytes == 64'd0)
      else $error("frame fields nonzero without frame");

   // A frame send never reports a drop
   a_send_no_drop: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && frame_valid |-> !packet_dropped)
      else $error("drop flagged on frame send");

endmodule

bind can_packet_segmenting_tx_ring_unit cpst_checker u_cpst_checker (
   .clock            (clock),
   .reset            (reset),
   .req_valid        (req_bus.valid),
   .req_ready        (req_bus.ready),
   .rsp_valid        (rsp_bus.valid),
   .rsp_ready        (rsp_bus.ready),
   .frame_valid      (rsp_bus.frame_valid),
   .frame_id         (rsp_bus.frame_id),
   .frame_bytes      (rsp_bus.frame_bytes),
   .packet_dropped   (rsp_bus.packet_dropped),
   .drop_count       (rsp_bus.drop_count),
   .free_frame_count (rsp_bus.free_frame_count)
);

@@ dv/testbench.sv @@
module testbench;
   import cpst_pkg::*;

   localparam int WATCHDOG_LIMIT = 3000;

   // One response as the ring unit reports it
   typedef struct packed {
      logic        frame_valid;
      logic [10:0] frame_id;
      logic [63:0] frame_bytes;
      logic        packet_dropped;
      logic [7:0]  drop_count;
      logic [4:0]  free_frame_count;
   } ring_outcome_type;

   logic clock = 1'b0;
   logic reset;
   logic csr_write_enable;
   logic [7:0] csr_write_data;

   cpst_req_if req_bus ();
   cpst_rsp_if rsp_bus ();

   can_packet_segmenting_tx_ring_unit u_top (
      .clock            (clock),
      .reset            (reset),
      .req_bus          (req_bus),
      .rsp_bus          (rsp_bus),
      .csr_write_enable (csr_write_enable),
      .csr_write_data   (csr_write_data)
   );

   always #5 clock = ~clock;

   // Shadow of the ring unit: frame store, pointers, open packet, drop counter
   logic [10:0] frame_id_store [RING_FRAMES];
   logic [63:0] frame_data_store [RING_FRAMES];
   logic [4:0]  pub_head;
   logic [4:0]  tx_tail;
   logic [6:0]  rx_count;
   logic [6:0]  pkt_len;
   logic [10:0] pkt_id;
   logic        pkt_open;
   logic [7:0]  drop_run;
   logic [7:0]  drop_limit;

   ring_outcome_type ring_outcome_q [$];

   int sent_count;
   int src_idle_pct;
   int sink_idle_pct;
   int stall_cycles;
   int stuck_cycles;
   bit failed;

   function automatic int frames_for(input logic [6:0] len);
      return (int'(len) + BYTES_PER_FRAME - 1) / BYTES_PER_FRAME;
   endfunction

   // Free frames: one slot always stays empty to tell full from empty
   function automatic logic [4:0] ring_free();
      return 5'(RING_FRAMES - 1) - (pub_head - tx_tail);
   endfunction

   // Advance the shadow by one request and return the response it causes
   function automatic ring_outcome_type segment_request(input mode_type m,
                                                        input logic [10:0] id,
                                                        input logic [6:0] len,
                                                        input logic [7:0] b);
      ring_outcome_type o;
      int need;
      int fidx;
      int off;
      logic [4:0] slot;
      o = '0;
      case (m)
         MODE_HEADER: begin
            need = frames_for(len);
            pkt_open = 1'b0;
            rx_count = '0;
            if (ring_free() < need) begin
               if (drop_run < drop_limit) drop_run++;
               o.packet_dropped = 1'b1;
            end else begin
               drop_run = '0;
               pkt_id   = id;
               pkt_len  = len;
               pkt_open = (len != 0);
            end
         end
         MODE_DATA: begin
            if (pkt_open) begin
               fidx = int'(rx_count) / BYTES_PER_FRAME;
               off  = int'(rx_count) % BYTES_PER_FRAME;
               slot = pub_head + 5'(fidx);
               // first byte of a frame lays down the header byte
               if (off == 0) begin
                  frame_id_store[slot]   = pkt_id;
                  frame_data_store[slot] = 64'({4'(fidx), 4'(frames_for(pkt_len)) & HDR_COUNT_MASK});
               end
               frame_data_store[slot] |= 64'(b) << (8 * (off + 1));
               rx_count = rx_count + 7'd1;
               // last byte publishes the whole packet
               if (rx_count >= pkt_len) begin
                  pub_head = pub_head + 5'(frames_for(pkt_len));
                  pkt_open = 1'b0;
               end
            end
         end
         MODE_MAILBOX_FREE: begin
            if (tx_tail != pub_head) begin
               o.frame_valid = 1'b1;
               o.frame_id    = frame_id_store[tx_tail];
               o.frame_bytes = frame_data_store[tx_tail];
               tx_tail       = tx_tail + 5'd1;
            end
         end
         default: ;
      endcase
      o.drop_count       = drop_run;
      o.free_frame_count = ring_free();
      return o;
   endfunction

   // Offer one request, wait for the handshake, then log its expected response
   task automatic send_req(input mode_type m, input logic [10:0] id, input logic [6:0] len,
                           input logic [7:0] b);
      while ($urandom_range(99) < src_idle_pct) begin
         req_bus.valid <= 1'b0;
         @(posedge clock);
      end
      req_bus.valid         <= 1'b1;
      req_bus.mode          <= m;
      req_bus.can_id        <= id;
      req_bus.packet_length <= len;
      req_bus.data_byte     <= b;
      @(posedge clock);
      while (!req_bus.ready) @(posedge clock);
      ring_outcome_q.push_back(segment_request(m, id, len, b));
      sent_count++;
   endtask

   task automatic send_rand(input mode_type m);
      send_req(m, 11'($urandom), 7'($urandom), 8'($urandom));
   endtask

   task automatic send_packet(input logic [10:0] id, input logic [6:0] len);
      send_req(MODE_HEADER, id, len, 8'($urandom));
      repeat (len) send_rand(MODE_DATA);
   endtask

   task automatic wait_idle();
      req_bus.valid <= 1'b0;
      while (ring_outcome_q.size() != 0) @(posedge clock);
      repeat (4) @(posedge clock);
   endtask

   task automatic write_drop_limit(input logic [7:0] value);
      wait_idle();
      csr_write_enable <= 1'b1;
      csr_write_data   <= value;
      @(posedge clock);
      drop_limit = value;
      csr_write_enable <= 1'b0;
   endtask

   task automatic check_field(input string name, input logic [63:0] want, input logic [63:0] got);
      if (want !== got) begin
         $error("%s: expected %0h, actual %0h", name, want, got);
         failed = 1'b1;
      end
   endtask

   // Short hand-picked sequence: field extremes and each corner of the protocol
   task automatic test_directed();
      send_rand(MODE_MAILBOX_FREE);                   // empty ring, no frame
      send_rand(MODE_RESERVED);                       // ignored mode
      send_req(MODE_DATA, 11'h7FF, 7'h7F, 8'hFF);     // no open packet
      send_req(MODE_HEADER, 11'h000, 7'd0, 8'h00);    // empty packet
      send_req(MODE_HEADER, 11'h7FF, 7'd1, 8'hFF);
      send_req(MODE_DATA, 11'h000, 7'd0, 8'hFF);
      send_req(MODE_DATA, 11'h000, 7'd0, 8'h00);      // extra byte after the last
      send_req(MODE_HEADER, 11'h555, 7'd127, 8'h00);  // longest length, left unfinished
      send_req(MODE_DATA, 11'h2AA, 7'h55, 8'hA5);
      send_req(MODE_DATA, 11'h555, 7'h2A, 8'h5A);
      send_packet(11'h2AA, 7'd8);                     // abandons the above, two frames
      repeat (3) send_rand(MODE_MAILBOX_FREE);
   endtask

   // Fill the ring, then walk the drop counter through its limits
   task automatic test_drop_limit();
      write_drop_limit(8'd3);
      repeat (2) send_packet(11'($urandom), 7'd105);  // 30 of 31 frames in use
      repeat (5) send_req(MODE_HEADER, 11'($urandom), 7'd14, 8'($urandom));
      write_drop_limit(8'd1);                         // limit under the count: hold
      send_req(MODE_HEADER, 11'($urandom), 7'd14, 8'($urandom));
      write_drop_limit(8'd0);
      send_req(MODE_HEADER, 11'($urandom), 7'd14, 8'($urandom));
      send_packet(11'($urandom), 7'd7);               // takes the last frame, clears count
      send_req(MODE_HEADER, 11'($urandom), 7'd1, 8'($urandom));
      send_req(MODE_HEADER, 11'($urandom), 7'd0, 8'($urandom));
      write_drop_limit(8'd255);
      repeat (260) send_req(MODE_HEADER, 11'($urandom), 7'($urandom_range(127, 1)),
                            8'($urandom));
      repeat (32) send_rand(MODE_MAILBOX_FREE);
   endtask

   // Receiver holds off while a packet streams in, so the unit stalls its input
   task automatic test_backpressure();
      stall_cycles = 300;
      send_packet(11'($urandom), 7'd40);
      repeat (6) send_rand(MODE_MAILBOX_FREE);
   endtask

   // Mostly well-formed packets with random content, plus noise and broken packets
   task automatic test_random_traffic(input int until_count, input int free_pct);
      int pick;
      int len;
      while (sent_count < until_count) begin
         pick = $urandom_range(99);
         if (pick < 80) begin
            pick = $urandom_range(99);
            len  = (pick < 70) ? $urandom_range(21) :
                   (pick < 92) ? $urandom_range(105) : $urandom_range(127, 106);
            send_req(MODE_HEADER, 11'($urandom), 7'(len), 8'($urandom));
            for (int i = 0; i < len; i++) begin
               if ($urandom_range(99) < free_pct) send_rand(MODE_MAILBOX_FREE);
               if ($urandom_range(199) == 0) break;  // cut short, next header abandons it
               send_rand(MODE_DATA);
            end
            if ($urandom_range(9) == 0) send_rand(MODE_DATA);
         end else if (pick < 92) begin
            send_rand(MODE_MAILBOX_FREE);
         end else if (pick < 95) begin
            send_rand(MODE_RESERVED);
         end else if (pick < 98) begin
            send_rand(MODE_DATA);
         end else begin
            send_rand(MODE_HEADER);
         end
      end
   endtask

   // Response side ready, with random idling and long hold-offs on request
   initial begin
      rsp_bus.ready = 1'b0;
      forever begin
         @(posedge clock);
         if (stall_cycles > 0) begin
            rsp_bus.ready <= 1'b0;
            stall_cycles--;
         end else begin
            rsp_bus.ready <= ($urandom_range(99) >= sink_idle_pct);
         end
      end
   end

   // Compare each response with the oldest expectation
   always @(posedge clock) begin : rsp_check
      ring_outcome_type want;
      if (!reset && rsp_bus.valid && rsp_bus.ready) begin
         if (ring_outcome_q.size() == 0) begin
            $error("response with nothing expected");
            failed = 1'b1;
         end else begin
            want = ring_outcome_q.pop_front();
            check_field("frame_valid", want.frame_valid, rsp_bus.frame_valid);
            check_field("frame_id", want.frame_id, rsp_bus.frame_id);
            check_field("frame_bytes", want.frame_bytes, rsp_bus.frame_bytes);
            check_field("packet_dropped", want.packet_dropped, rsp_bus.packet_dropped);
            check_field("drop_count", want.drop_count, rsp_bus.drop_count);
            check_field("free_frame_count", want.free_frame_count, rsp_bus.free_frame_count);
         end
      end
   end

   // Watchdog on cycles with no handshake on either side
   always @(posedge clock) begin
      if (reset || (req_bus.valid && req_bus.ready) || (rsp_bus.valid && rsp_bus.ready)) begin
         stuck_cycles = 0;
      end else begin
         stuck_cycles++;
      end
      if (stuck_cycles >= WATCHDOG_LIMIT) begin
         $display("Verification failed");
         $finish;
      end
   end

   initial begin
      reset                 = 1'b1;
      csr_write_enable      = 1'b0;
      csr_write_data        = '0;
      req_bus.valid         = 1'b0;
      req_bus.mode          = MODE_HEADER;
      req_bus.can_id        = '0;
      req_bus.packet_length = '0;
      req_bus.data_byte     = '0;
      pub_head              = '0;
      tx_tail               = '0;
      rx_count              = '0;
      pkt_len               = '0;
      pkt_id                = '0;
      pkt_open              = 1'b0;
      drop_run              = '0;
      drop_limit            = DROP_LIMIT_RESET;
      sent_count            = 0;
      stall_cycles          = 0;
      stuck_cycles          = 0;
      failed                = 1'b0;
      src_idle_pct          = 18;
      sink_idle_pct         = 86;
      repeat (7) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      test_directed();
      test_drop_limit();
      test_random_traffic(750, 5);
      write_drop_limit(8'd2);
      test_random_traffic(950, 60);

      src_idle_pct  = 86;
      sink_idle_pct = 18;
      test_backpressure();
      write_drop_limit(8'($urandom_range(254, 1)));
      test_random_traffic(1200, 10);
      write_drop_limit(8'd255);
      test_random_traffic(1450, 50);

      src_idle_pct  = 0;
      sink_idle_pct = 0;
      write_drop_limit(8'd1);
      test_random_traffic(1700, 4);
      write_drop_limit(8'($urandom_range(254, 1)));
      test_random_traffic(1950, 45);

      wait_idle();
      repeat (8) @(posedge clock);
      if (!failed && ring_outcome_q.size() == 0) begin
         $display("Verification passed");
      end else begin
         $display("Verification failed");
      end
      $finish;
   end

endmodule

@@ sim.f @@
hdl/cpst_pkg.sv
hdl/cpst_if.sv
hdl/cpst_ctrl.sv
hdl/cpst_dpath.sv
hdl/can_packet_segmenting_tx_ring_unit.sv
hdl/cpst_checker.sv
dv/testbench.sv
